>>> rtl/core/stt_pkg.sv
// Shared types and constants for the spline trail tessellator.
// Holds the item structs, window row layout and Catmull-Rom weight table.
// No dependencies.
package stt_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int WIN_PAIRS   = 4;
  localparam int LANES       = 3;
  localparam int WGT_W       = 9;
  localparam int PRD_W       = COORD_WIDTH + WGT_W;
  localparam int ACC_W       = PRD_W + 2;
  localparam int ROUND_SHIFT = 7;
  localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(64);

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [1:0] LAST_SLOT = 2'd3;
  localparam logic [3:0] LAST_VERT = 4'd15;

  // Curve weights in 1/128ths, row = s in quarters, column = P0..P3
  localparam logic signed [WGT_W-1:0] SPLINE_W [5][4] = '{
    '{ 9'sd0,   9'sd128,  9'sd0,   9'sd0 },
    '{-9'sd9,   9'sd111,  9'sd29, -9'sd3 },
    '{-9'sd8,   9'sd72,   9'sd72, -9'sd8 },
    '{-9'sd3,   9'sd29,   9'sd111, -9'sd9 },
    '{ 9'sd0,   9'sd0,    9'sd128, 9'sd0 }
  };

  typedef struct packed {
    logic                          trail_select;
    logic signed [COORD_WIDTH-1:0] tip_x;
    logic signed [COORD_WIDTH-1:0] tip_y;
    logic signed [COORD_WIDTH-1:0] tip_z;
    logic signed [COORD_WIDTH-1:0] base_x;
    logic signed [COORD_WIDTH-1:0] base_y;
    logic signed [COORD_WIDTH-1:0] base_z;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] vert_x;
    logic signed [COORD_WIDTH-1:0] vert_y;
    logic signed [COORD_WIDTH-1:0] vert_z;
    logic [2:0]                    tex_u;
    logic                          tex_v;
    logic                          last_vertex;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] tip_x;
    logic signed [COORD_WIDTH-1:0] tip_y;
    logic signed [COORD_WIDTH-1:0] tip_z;
    logic signed [COORD_WIDTH-1:0] base_x;
    logic signed [COORD_WIDTH-1:0] base_y;
    logic signed [COORD_WIDTH-1:0] base_z;
  } pair_t;

  // One full window, pair[0] oldest
  typedef struct packed {
    pair_t [WIN_PAIRS-1:0] pair;
  } snap_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

>>> rtl/core/stt_front.sv
// Front end: accepts point pairs, keeps per-channel windows in a small RAM,
// and snapshots a full window into the job queue. Depends on stt_pkg.
module stt_front #(
  parameter int CHANNELS = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  stt_pkg::in_item_t in_item,
  input  stt_pkg::q_stat_t  q_stat,
  output logic              q_push,
  output stt_pkg::snap_t    q_data
);

  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DEPTH  = CHANNELS * stt_pkg::WIN_PAIRS;
  localparam int ADDR_W = $clog2(DEPTH);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_READ = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  fstate_t state_r, state_nxt;

  logic [1:0]      held_r [CHANNELS];
  logic [1:0]      head_r [CHANNELS];
  logic [CH_W-1:0] rd_ch_r;
  logic [1:0]      rd_base_r;
  logic [1:0]      rd_cnt_r;

  stt_pkg::pair_t  win_mem [DEPTH];
  stt_pkg::pair_t  rd_data_r;
  stt_pkg::snap_t  snap_r;
  stt_pkg::pair_t  new_row;

  logic              accept;
  logic              sel_ok;
  logic              wr_en;
  logic              win_done;
  logic [CH_W-1:0]   ch;
  logic [1:0]        cur_held;
  logic [1:0]        cur_head;
  logic [1:0]        wr_slot;
  logic [1:0]        rd_slot;
  logic [1:0]        cap_idx;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;

  always_comb begin
    full     = (state_r != F_IDLE);
    accept   = push && !full;
    ch       = CH_W'(in_item.trail_select);
    sel_ok   = (int'(in_item.trail_select) < CHANNELS);
    wr_en    = accept && sel_ok;
    cur_held = held_r[ch];
    cur_head = head_r[ch];
    wr_slot  = cur_head + cur_held;
    win_done = wr_en && (cur_held == stt_pkg::LAST_SLOT);
    wr_addr  = ADDR_W'({ch, wr_slot});
    rd_slot  = rd_base_r + rd_cnt_r;
    cap_idx  = rd_cnt_r - 2'd1;
    rd_addr  = (state_r == F_READ) ? ADDR_W'({rd_ch_r, rd_slot}) : ADDR_W'({ch, cur_head});
    q_push   = (state_r == F_PUSH) && !q_stat.full;
    q_data   = snap_r;

    new_row.tip_x  = in_item.tip_x;
    new_row.tip_y  = in_item.tip_y;
    new_row.tip_z  = in_item.tip_z;
    new_row.base_x = in_item.base_x;
    new_row.base_y = in_item.base_y;
    new_row.base_z = in_item.base_z;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: begin
        if (win_done) state_nxt = F_READ;
      end
      F_READ: begin
        if (rd_cnt_r == stt_pkg::LAST_SLOT) state_nxt = F_PUSH;
      end
      F_PUSH: begin
        if (!q_stat.full) state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= F_IDLE;
      rd_cnt_r <= 2'd0;
      for (int c = 0; c < CHANNELS; c++) begin
        held_r[c] <= 2'd0;
        head_r[c] <= 2'd0;
      end
    end else begin
      state_r <= state_nxt;
      if (wr_en) begin
        // full window: slide by advancing the head, count stays at three
        if (win_done) head_r[ch] <= cur_head + 2'd1;
        else          held_r[ch] <= cur_held + 2'd1;
      end
      if (win_done)                rd_cnt_r <= 2'd1;
      else if (state_r == F_READ)  rd_cnt_r <= rd_cnt_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) win_mem[wr_addr] <= new_row;
    rd_data_r <= win_mem[rd_addr];
    if (win_done) begin
      snap_r.pair[stt_pkg::WIN_PAIRS-1] <= new_row;
      rd_ch_r   <= ch;
      rd_base_r <= cur_head;
    end
    if (state_r == F_READ) snap_r.pair[cap_idx] <= rd_data_r;
  end

endmodule

>>> rtl/core/stt_queue.sv
// Two-entry job queue of full windows between front end and back end.
// Depends on stt_pkg.
module stt_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  stt_pkg::snap_t   push_data,
  input  logic             pop,
  output stt_pkg::q_stat_t stat,
  output stt_pkg::snap_t   head
);

  stt_pkg::snap_t                q_r [stt_pkg::Q_DEPTH];
  logic [stt_pkg::Q_PTR_W-1:0]   wr_ptr_r;
  logic [stt_pkg::Q_PTR_W-1:0]   rd_ptr_r;
  logic [stt_pkg::Q_CNT_W-1:0]   cnt_r;
  logic                          do_push;
  logic                          do_pop;

  always_comb begin
    stat.full  = (cnt_r == stt_pkg::Q_CNT_W'(stt_pkg::Q_DEPTH));
    stat.empty = (cnt_r == '0);
    do_push    = push && !stat.full;
    do_pop     = pop && !stat.empty;
    head       = q_r[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) q_r[wr_ptr_r] <= push_data;
  end

endmodule

>>> rtl/core/stt_back.sv
// Back end: walks the sixteen vertices of one window, three coordinate
// lanes of four-tap products, then round, saturate and output register.
// Depends on stt_pkg.
module stt_back (
  input  logic               clk,
  input  logic               rst_n,
  input  stt_pkg::q_stat_t   q_stat,
  input  stt_pkg::snap_t     q_head,
  output logic               q_pop,
  output logic               empty,
  input  logic               pop,
  output stt_pkg::out_item_t out_item
);

  localparam int CW = stt_pkg::COORD_WIDTH;
  localparam int PW = stt_pkg::PRD_W;
  localparam int AW = stt_pkg::ACC_W;

  logic [3:0]           vcnt_r;
  logic                 s1_valid_r;
  logic signed [PW-1:0] s1_prod_r [stt_pkg::LANES][stt_pkg::WIN_PAIRS];
  logic [2:0]           s1_u_r;
  logic                 s1_v_r;
  logic                 s1_last_r;
  logic                 out_valid_r;
  stt_pkg::out_item_t   out_item_r;

  logic                 en;
  logic                 issue;
  logic [1:0]           corner;
  logic [1:0]           quad;
  logic                 step;
  logic [2:0]           sidx;
  logic                 on_base;
  logic signed [CW-1:0] pts_c [stt_pkg::WIN_PAIRS][stt_pkg::LANES];
  logic signed [PW-1:0] prod_c [stt_pkg::LANES][stt_pkg::WIN_PAIRS];
  logic signed [stt_pkg::WGT_W-1:0] wgt;
  logic signed [AW-1:0] acc_c [stt_pkg::LANES];
  logic signed [AW-1:0] sh_c [stt_pkg::LANES];
  logic [AW-CW:0]       hi_c [stt_pkg::LANES];
  logic signed [CW-1:0] vert_c [stt_pkg::LANES];
  stt_pkg::out_item_t   out_c;

  // Stage 1: vertex decode and products
  always_comb begin
    en      = !out_valid_r || pop;
    issue   = en && !q_stat.empty;
    q_pop   = issue && (vcnt_r == stt_pkg::LAST_VERT);
    corner  = vcnt_r[1:0];
    quad    = vcnt_r[3:2];
    // quad corners: before-tip, after-tip, after-base, before-base
    step    = (corner == 2'd1) || (corner == 2'd2);
    sidx    = {1'b0, quad} + {2'b00, step};
    on_base = corner[1];
    wgt     = '0;
    for (int k = 0; k < stt_pkg::WIN_PAIRS; k++) begin
      pts_c[k][0] = on_base ? q_head.pair[k].base_x : q_head.pair[k].tip_x;
      pts_c[k][1] = on_base ? q_head.pair[k].base_y : q_head.pair[k].tip_y;
      pts_c[k][2] = on_base ? q_head.pair[k].base_z : q_head.pair[k].tip_z;
    end
    for (int k = 0; k < stt_pkg::WIN_PAIRS; k++) begin
      wgt = stt_pkg::SPLINE_W[sidx][k];
      for (int a = 0; a < stt_pkg::LANES; a++) begin
        prod_c[a][k] = $signed({{stt_pkg::WGT_W{pts_c[k][a][CW-1]}}, pts_c[k][a]})
                     * $signed({{CW{wgt[stt_pkg::WGT_W-1]}}, wgt});
      end
    end
  end

  // Stage 2: sum, round half up, saturate
  always_comb begin
    for (int a = 0; a < stt_pkg::LANES; a++) begin
      acc_c[a] = stt_pkg::ROUND_BIAS;
      for (int k = 0; k < stt_pkg::WIN_PAIRS; k++) begin
        acc_c[a] = acc_c[a] + {{(AW-PW){s1_prod_r[a][k][PW-1]}}, s1_prod_r[a][k]};
      end
      sh_c[a] = acc_c[a] >>> stt_pkg::ROUND_SHIFT;
      hi_c[a] = sh_c[a][AW-1:CW-1];
      if ((&hi_c[a]) || !(|hi_c[a])) vert_c[a] = sh_c[a][CW-1:0];
      else if (hi_c[a][AW-CW])       vert_c[a] = {1'b1, {(CW-1){1'b0}}};
      else                           vert_c[a] = {1'b0, {(CW-1){1'b1}}};
    end
    out_c.vert_x      = vert_c[0];
    out_c.vert_y      = vert_c[1];
    out_c.vert_z      = vert_c[2];
    out_c.tex_u       = s1_u_r;
    out_c.tex_v       = s1_v_r;
    out_c.last_vertex = s1_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcnt_r      <= 4'd0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en) begin
        s1_valid_r  <= issue;
        out_valid_r <= s1_valid_r;
      end
      if (issue) vcnt_r <= vcnt_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_prod_r  <= prod_c;
      s1_u_r     <= sidx;
      s1_v_r     <= on_base;
      s1_last_r  <= (vcnt_r == stt_pkg::LAST_VERT);
      out_item_r <= out_c;
    end
  end

  assign empty    = !out_valid_r;
  assign out_item = out_item_r;

endmodule

>>> rtl/core/spline_trail_tessellator.sv
// Top level of the spline trail tessellator: front end, job queue, back end.
// Depends on stt_pkg, stt_front, stt_queue and stt_back.
//
// Catmull-Rom ribbon tessellator for blade trails. Each input item is one
// tip/base point pair for one of CHANNELS trail channels. A channel keeps the
// last four pairs; every item after the third on a channel produces sixteen
// vertex items (four quads: before-tip, after-tip, after-base, before-base)
// sampled at s = 0, 1/4, 1/2, 3/4, 1, and the oldest pair slides out.
// Timing: an item that only fills a window never raises full, and such items
// can follow back to back. An item that completes a window raises full until
// its snapshot is in the job queue: the front end reads the three older pairs
// out of the window RAM and hands the snapshot to a two-deep job queue,
// waiting while that queue is full. The back end emits one vertex per cycle
// while a window is queued and the consumer keeps popping, through a
// two-stage pipeline (products, then sum/round/saturate into the output
// register), so a run of full windows is limited by that vertex lane at
// sixteen vertices per window. The first vertex follows the completing item
// through the window read, the job queue and both pipeline registers.
// Inputs whose trail_select is at or above CHANNELS are taken and dropped.
// No reset sweep is needed: window rows are only read after being written.
module spline_trail_tessellator #(
  parameter int CHANNELS = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  // input queue side
  input  logic               push,
  output logic               full,
  input  stt_pkg::in_item_t  in_item,
  // result queue side
  output logic               empty,
  input  logic               pop,
  output stt_pkg::out_item_t out_item
);

  stt_pkg::q_stat_t q_stat;
  stt_pkg::snap_t   q_data;
  stt_pkg::snap_t   q_head;
  logic             q_push;
  logic             q_pop;

  stt_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .q_stat  (q_stat),
    .q_push  (q_push),
    .q_data  (q_data)
  );

  stt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .stat      (q_stat),
    .head      (q_head)
  );

  stt_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_stat   (q_stat),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

  // back end only retires a window that is actually queued
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("window retired from empty queue");

  // front end never drops a snapshot into a full queue
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("snapshot pushed into full queue");

  // mid-run vertices come out without gaps once the consumer takes one
  a_run_gapless: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && pop && !out_item.last_vertex) |=> !empty)
    else $error("gap inside a vertex run");

  // the closing vertex is the before-base corner of the last quad
  a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_item.last_vertex) |-> (out_item.tex_u == 3'd3 && out_item.tex_v))
    else $error("last vertex flag on wrong corner");

endmodule
